/* src/rau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CmdW  = 3;
    localparam int unsigned CntW  = $clog2(DataW);

    typedef enum logic [CmdW-1:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_LT   = 3'd4,
        CMD_GT   = 3'd5,
        CMD_EQ   = 3'd6,
        CMD_NE   = 3'd7
    } cmd_t;

    typedef struct packed {
        logic                    start;
        logic signed [DataW-1:0] dividend;
        logic signed [DataW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [DataW-1:0] quo;
        logic signed [DataW-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

/* src/rational_arith_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Rational arithmetic unit: takes two fractions and a command (add, sub, mul, div, or one of
// four comparisons) and returns one reduced fraction, a truth bit and a division-by-zero flag.
// Every reduction runs Euclid's algorithm on one shared 32-bit iterative divider (one quotient
// bit per cycle while busy), followed by two divisions by the gcd; a transaction needs up to
// four reductions (none on a zero denominator of a, four for a subtraction). Products come
// from one registered 32x32 multiplier (low 32 bits kept), one per cycle. The input is not
// ready while a transaction is in progress.
module rational_arith_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // a_num, a_den, b_num, b_den
    input  wire logic [2:0]   s_tuser,  // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,  // res_num, res_den
    output logic [1:0]        m_tuser   // truth, error
);

    localparam int unsigned W = rau_pkg::DataW;

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_GCD_CHK  = 14'b00000000000010,
        ST_GCD_WAIT = 14'b00000000000100,
        ST_DIV_N    = 14'b00000000001000,
        ST_DIV_D_GO = 14'b00000000010000,
        ST_DIV_D    = 14'b00000000100000,
        ST_RED_DONE = 14'b00000001000000,
        ST_M1       = 14'b00000010000000,
        ST_M2       = 14'b00000100000000,
        ST_M3       = 14'b00001000000000,
        ST_M4       = 14'b00010000000000,
        ST_M5       = 14'b00100000000000,
        ST_OUT      = 14'b01000000000000,
        ST_SPARE    = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_A   = 2'd0,
        PH_B   = 2'd1,
        PH_NEG = 2'd2,
        PH_RES = 2'd3
    } phase_t;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    rau_pkg::cmd_t         cmd_reg, cmd_next;
    logic signed [W-1:0]   an_reg, an_next, ad_reg, ad_next;
    logic signed [W-1:0]   bn_reg, bn_next, bd_reg, bd_next;
    logic signed [W-1:0]   n_reg, n_next, d_reg, d_next;
    logic signed [W-1:0]   ga_reg, ga_next, gb_reg, gb_next;
    logic signed [W-1:0]   l_reg, l_next, r_reg, r_next;
    logic signed [W-1:0]   dd_reg, dd_next;
    logic signed [W-1:0]   rnum_reg, rnum_next, rden_reg, rden_next;
    logic                  rtruth_reg, rtruth_next, rerr_reg, rerr_next;
    logic                  mvalid_reg, mvalid_next;
    logic [63:0]           mdata_reg, mdata_next;
    logic [1:0]            muser_reg, muser_next;
    logic signed [W-1:0]   mul_x, mul_y, mul_p;
    rau_pkg::div_req_t     div_req;
    rau_pkg::div_rsp_t     div_rsp;

    rau_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rau_mul u_mul (
        .aclk (aclk),
        .x    (mul_x),
        .y    (mul_y),
        .p    (mul_p)
    );

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        dd_next     = dd_reg;
        rnum_next   = rnum_reg;
        rden_next   = rden_reg;
        rtruth_next = rtruth_reg;
        rerr_next   = rerr_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mul_x       = '0;
        mul_y       = '0;
        div_req.start    = 1'b0;
        div_req.dividend = ga_reg;
        div_req.divisor  = gb_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = rau_pkg::cmd_t'(s_tuser);
                    an_next   = s_tdata[31:0];
                    ad_next   = s_tdata[63:32];
                    bn_next   = s_tdata[95:64];
                    bd_next   = s_tdata[127:96];
                    rnum_next   = '0;
                    rden_next   = W'(1);
                    rtruth_next = 1'b0;
                    rerr_next   = 1'b1;
                    if (s_tdata[63:32] == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        n_next     = s_tdata[31:0];
                        d_next     = s_tdata[63:32];
                        ga_next    = s_tdata[31:0];
                        gb_next    = s_tdata[63:32];
                        phase_next = PH_A;
                        state_next = ST_GCD_CHK;
                    end
                end
            end
            ST_GCD_CHK: begin
                if (gb_reg != '0) begin
                    div_req.start = 1'b1;
                    state_next    = ST_GCD_WAIT;
                end else if (ga_reg == '0) begin
                    // both parts zero: leave the fraction as it is
                    state_next = ST_RED_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = n_reg;
                    div_req.divisor  = ga_reg;
                    state_next       = ST_DIV_N;
                end
            end
            ST_GCD_WAIT: begin
                if (div_rsp.done) begin
                    ga_next    = gb_reg;
                    gb_next    = div_rsp.rem;
                    state_next = ST_GCD_CHK;
                end
            end
            ST_DIV_N: begin
                if (div_rsp.done) begin
                    n_next     = div_rsp.quo;
                    state_next = ST_DIV_D_GO;
                end
            end
            ST_DIV_D_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = d_reg;
                div_req.divisor  = ga_reg;
                state_next       = ST_DIV_D;
            end
            ST_DIV_D: begin
                if (div_rsp.done) begin
                    d_next     = div_rsp.quo;
                    state_next = ST_RED_DONE;
                end
            end
            ST_RED_DONE: begin
                case (phase_reg)
                    PH_A: begin
                        an_next = n_reg;
                        ad_next = d_reg;
                        if (bd_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            n_next     = bn_reg;
                            d_next     = bd_reg;
                            ga_next    = bn_reg;
                            gb_next    = bd_reg;
                            phase_next = PH_B;
                            state_next = ST_GCD_CHK;
                        end
                    end
                    PH_B, PH_NEG: begin
                        bn_next    = n_reg;
                        bd_next    = d_reg;
                        state_next = ST_M1;
                    end
                    default: begin
                        rnum_next  = n_reg;
                        rden_next  = d_reg;
                        rerr_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_M1: begin
                mul_x      = an_reg;
                mul_y      = bd_reg;
                state_next = ST_M2;
            end
            ST_M2: begin
                l_next     = mul_p;
                mul_x      = ad_reg;
                mul_y      = bn_reg;
                state_next = ST_M3;
            end
            ST_M3: begin
                r_next     = mul_p;
                mul_x      = ad_reg;
                mul_y      = bd_reg;
                state_next = ST_M4;
            end
            ST_M4: begin
                dd_next    = mul_p;
                mul_x      = an_reg;
                mul_y      = bn_reg;
                state_next = ST_M5;
            end
            ST_M5: begin
                state_next = ST_OUT;
                case (cmd_reg)
                    rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                        if (cmd_reg == rau_pkg::CMD_SUB && phase_reg == PH_B) begin
                            // reduce the negation of b before adding
                            n_next     = -bn_reg;
                            d_next     = bd_reg;
                            ga_next    = -bn_reg;
                            gb_next    = bd_reg;
                            phase_next = PH_NEG;
                        end else begin
                            n_next     = l_reg + r_reg;
                            d_next     = dd_reg;
                            ga_next    = l_reg + r_reg;
                            gb_next    = dd_reg;
                            phase_next = PH_RES;
                        end
                        state_next = ST_GCD_CHK;
                    end
                    rau_pkg::CMD_MUL: begin
                        if (dd_reg != '0) begin
                            n_next     = mul_p;
                            d_next     = dd_reg;
                            ga_next    = mul_p;
                            gb_next    = dd_reg;
                            phase_next = PH_RES;
                            state_next = ST_GCD_CHK;
                        end
                    end
                    rau_pkg::CMD_DIV: begin
                        // swapped b: numerator a_n*b_d, denominator a_d*b_n
                        if (bn_reg != '0 && r_reg != '0) begin
                            n_next     = l_reg;
                            d_next     = r_reg;
                            ga_next    = l_reg;
                            gb_next    = r_reg;
                            phase_next = PH_RES;
                            state_next = ST_GCD_CHK;
                        end
                    end
                    rau_pkg::CMD_LT: begin
                        rtruth_next = l_reg < r_reg;
                        rerr_next   = 1'b0;
                    end
                    rau_pkg::CMD_GT: begin
                        rtruth_next = l_reg > r_reg;
                        rerr_next   = 1'b0;
                    end
                    rau_pkg::CMD_EQ: begin
                        rtruth_next = l_reg == r_reg;
                        rerr_next   = 1'b0;
                    end
                    default: begin
                        rtruth_next = l_reg != r_reg;
                        rerr_next   = 1'b0;
                    end
                endcase
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {rden_reg, rnum_reg};
                    muser_next  = {rerr_reg, rtruth_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        phase_reg  <= phase_next;
        cmd_reg    <= cmd_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        dd_reg     <= dd_next;
        rnum_reg   <= rnum_next;
        rden_reg   <= rden_next;
        rtruth_reg <= rtruth_next;
        rerr_reg   <= rerr_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule
`default_nettype wire

/* src/rau_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module rau_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t      rsp
);

    localparam int unsigned W = rau_pkg::DataW;

    logic [W-1:0]               q_reg, q_next;
    logic [W-1:0]               r_reg, r_next;
    logic [W-1:0]               ub_reg, ub_next;
    logic [rau_pkg::CntW-1:0]   cnt_reg, cnt_next;
    logic                       negq_reg, negq_next;
    logic                       negr_reg, negr_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [W:0]                 shifted;
    logic [W:0]                 diff;

    always_comb begin
        shifted   = {r_reg, q_reg[W-1]};
        diff      = shifted - {1'b0, ub_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        ub_next   = ub_reg;
        cnt_next  = cnt_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            // work on magnitudes; the most negative value maps onto its own bit pattern
            q_next    = req.dividend[W-1] ? W'(-req.dividend) : W'(req.dividend);
            ub_next   = req.divisor[W-1] ? W'(-req.divisor) : W'(req.divisor);
            r_next    = '0;
            cnt_next  = '0;
            negq_next = req.dividend[W-1] ^ req.divisor[W-1];
            negr_next = req.dividend[W-1];
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                r_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = shifted[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rau_pkg::CntW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg    <= q_next;
        r_reg    <= r_next;
        ub_reg   <= ub_next;
        cnt_reg  <= cnt_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = negq_reg ? -$signed(q_reg) : $signed(q_reg);
    assign rsp.rem  = negr_reg ? -$signed(r_reg) : $signed(r_reg);

endmodule
`default_nettype wire

/* src/rau_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module rau_mul (
    input  wire logic                                aclk,
    input  wire logic signed [rau_pkg::DataW-1:0]    x,
    input  wire logic signed [rau_pkg::DataW-1:0]    y,
    output logic signed [rau_pkg::DataW-1:0]         p
);

    logic signed [rau_pkg::DataW-1:0] p_reg, p_next;

    // low half only: the product wraps as a 32-bit int
    assign p_next = x * y;

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* src/rau_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module rau_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [1:0]   m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 64'h0000_0001_0000_0000 && !m_tuser[0])
        else $error("error result not zero over one");

    a_truth_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'h0000_0001_0000_0000)
        else $error("comparison result carries a fraction");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
